### sv/rtc_pkg.sv
// Shared types and constants for the request tag completion tracker.
// No dependencies; used by rtc_cell, rtc_ctrl and request_tag_completion_tracker.
`default_nettype none

package rtc_pkg;

  localparam int TAG_COUNT_DEF = 32;

  // Field widths of the stream payloads
  localparam int OPC_W       = 2;
  localparam int QTAG_W      = 8;
  localparam int BUSY_W      = 32;
  localparam int GTAG_W      = 5;
  localparam int OUTS_W      = 6;
  localparam int IN_TDATA_W  = 40;  // query_tag + busy_mask, whole bytes
  localparam int RES_W       = GTAG_W + 1 + 1 + 1 + OUTS_W;
  localparam int OUT_TDATA_W = 16;

  // Opcodes
  localparam logic [OPC_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPC_W-1:0] OP_QONE  = 2'd1;
  localparam logic [OPC_W-1:0] OP_QALL  = 2'd2;
  localparam logic [OPC_W-1:0] OP_RENEW = 2'd3;

  // Tag status codes
  localparam logic [1:0] TS_FREE = 2'd0;
  localparam logic [1:0] TS_REQ  = 2'd1;
  localparam logic [1:0] TS_ISS  = 2'd2;

  // Broadcast controls from the controller to every cell
  typedef struct packed {
    logic alloc;   // cell at sel_ptr becomes requested
    logic renew;   // renew tick, every cell at once
    logic load;    // retire token placed at sel_ptr
    logic walk;    // token holder frees itself, token moves one cell on
  } rtc_cell_ctl_t;

endpackage

`default_nettype wire

### sv/request_tag_completion_tracker.sv
// Top level: a ring of tag cells chained by the retire token, and the controller.
// Depends on rtc_pkg, rtc_cell and rtc_ctrl.
//
//   channel | dir | tdata (low bit up)                              | tuser
//   in_     | in  | query_tag[7:0], busy_mask[39:8]                   | opcode[1:0]
//   out_    | out | granted_tag[4:0], grant_ok[5], finished[6],      | -
//           |     | any_pending[7], outstanding[13:8], zero pad      |
//
// Allocate, renew and queries that retire nothing pass from idle through the
// execute and finish states; out_tvalid and in_tready rise together as finish completes.
// A retiring query walks the token one cell per retired tag (1..TAG_COUNT) along
// the cell chain between execute and finish. One item is in flight at a time; in_tready is high
// only while idle. A result held by out_tready low keeps the next item from
// finishing, not from being accepted. Synchronous reset frees every tag.
`default_nettype none

module request_tag_completion_tracker
  import rtc_pkg::*;
#(
  parameter int TAG_COUNT = TAG_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // query_tag, busy_mask
  input  wire logic [OPC_W-1:0]       in_tuser,   // opcode
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // granted_tag, grant_ok, finished,
                                                  // any_pending, outstanding
);

  localparam int TW = $clog2(TAG_COUNT);

  rtc_cell_ctl_t              cell_ctl;
  logic [TW-1:0]              sel_ptr;
  logic [BUSY_W-1:0]          busy;
  logic [TAG_COUNT-1:0][1:0]  status;
  logic [TAG_COUNT-1:0]       token;
  logic [TAG_COUNT-1:0]       busy_bit;

  rtc_ctrl #(
    .TAG_COUNT (TAG_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .status     (status),
    .cell_ctl   (cell_ctl),
    .sel_ptr    (sel_ptr),
    .busy       (busy)
  );

  for (genvar i = 0; i < TAG_COUNT; i++) begin : g_cell
    // tags past the mask width see a clear busy bit
    if (i < BUSY_W) begin : g_busy
      assign busy_bit[i] = busy[i];
    end else begin : g_nobusy
      assign busy_bit[i] = 1'b0;
    end

    rtc_cell #(
      .TAG_COUNT (TAG_COUNT),
      .IDX       (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .sel_ptr   (sel_ptr),
      .busy_bit  (busy_bit[i]),
      .token_in  (token[(i + TAG_COUNT - 1) % TAG_COUNT]),
      .token_out (token[i]),
      .status    (status[i])
    );
  end

endmodule

`default_nettype wire

### sv/rtc_cell.sv
// One ring entry: the status of a single tag plus its slot of the retire token chain.
// Depends on rtc_pkg.
`default_nettype none

module rtc_cell
  import rtc_pkg::*;
#(
  parameter int TAG_COUNT = TAG_COUNT_DEF,
  parameter int IDX       = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rtc_cell_ctl_t                ctl,
  input  wire logic [$clog2(TAG_COUNT)-1:0] sel_ptr,
  input  wire logic                         busy_bit,
  input  wire logic                         token_in,
  output logic                              token_out,
  output logic [1:0]                        status
);

  localparam int TW = $clog2(TAG_COUNT);
  localparam logic [TW-1:0] MY_IDX = TW'(IDX);

  logic [1:0] status_r, status_nxt;
  logic       token_r, token_nxt;
  logic       hit;

  assign hit = (sel_ptr == MY_IDX);

  always_comb begin
    status_nxt = status_r;
    if (ctl.alloc && hit) begin
      status_nxt = TS_REQ;
    end else if (ctl.renew) begin
      case (status_r)
        TS_REQ:  status_nxt = TS_ISS;
        TS_ISS:  status_nxt = busy_bit ? TS_ISS : TS_FREE;
        default: status_nxt = status_r;
      endcase
    end else if (ctl.walk && token_r) begin
      status_nxt = TS_FREE;
    end
  end

  always_comb begin
    token_nxt = token_r;
    if (ctl.load) begin
      token_nxt = hit;
    end else if (ctl.walk) begin
      token_nxt = token_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= TS_FREE;
      token_r  <= 1'b0;
    end else begin
      status_r <= status_nxt;
      token_r  <= token_nxt;
    end
  end

  assign status    = status_r;
  assign token_out = token_r;

endmodule

`default_nettype wire

### sv/rtc_ctrl.sv
// Ring controller: pointers, outstanding count, sequencer and the result register.
// Depends on rtc_pkg; drives the row of rtc_cell instances.
`default_nettype none

module rtc_ctrl
  import rtc_pkg::*;
#(
  parameter int TAG_COUNT = TAG_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [OPC_W-1:0]                  in_tuser,
  input  wire logic [IN_TDATA_W-1:0]             in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [OUT_TDATA_W-1:0]                 out_tdata,
  input  wire logic [TAG_COUNT-1:0][1:0]         status,
  output rtc_cell_ctl_t                          cell_ctl,
  output logic [$clog2(TAG_COUNT)-1:0]           sel_ptr,
  output logic [BUSY_W-1:0]                      busy
);

  localparam int TW  = $clog2(TAG_COUNT);
  localparam int CW  = $clog2(TAG_COUNT + 1);
  localparam int SW  = CW + 1;
  localparam int GEW = TW + GTAG_W;
  localparam int OEW = CW + OUTS_W;
  localparam logic [QTAG_W:0] TC_Q   = (QTAG_W + 1)'(TAG_COUNT);
  localparam logic [CW-1:0]   TC_C   = CW'(TAG_COUNT);
  localparam logic [SW-1:0]   TC_S   = SW'(TAG_COUNT);
  localparam logic [TW-1:0]   LAST_T = TW'(TAG_COUNT - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [OPC_W-1:0]       op_r, op_nxt;
  logic [QTAG_W-1:0]      tag_r, tag_nxt;
  logic [BUSY_W-1:0]      busy_r, busy_nxt;
  logic [TW-1:0]          oldest_r, oldest_nxt;
  logic [TW-1:0]          next_ptr_r, next_ptr_nxt;
  logic [CW-1:0]          live_r, live_nxt;
  logic [CW-1:0]          walk_cnt_r, walk_cnt_nxt;
  logic [RES_W-1:0]       res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Query decode
  logic          tag_oor;
  logic [TW-1:0] tag_idx;
  logic [TW-1:0] dist_one;
  logic [SW-1:0] sum_all;
  logic [SW-1:0] last_s;
  logic [TW-1:0] target;
  logic [TW-1:0] q_span;
  logic [CW-1:0] dist_c;
  logic          outside;
  logic          pending_hit;
  logic [TW-1:0] target_next;
  logic [TW-1:0] next_ptr_inc;

  logic [GTAG_W-1:0] granted;
  logic              grant_ok;
  logic              fin;
  logic [GEW-1:0]    granted_ext;
  logic [OEW-1:0]    live_ext;

  assign tag_oor = ({1'b0, tag_r} >= TC_Q);
  assign tag_idx = tag_r[TW-1:0];

  always_comb begin
    if (tag_idx >= oldest_r) begin
      dist_one = tag_idx - oldest_r;
    end else begin
      dist_one = TW'((TW + 1)'(tag_idx) + (TW + 1)'(TAG_COUNT) - (TW + 1)'(oldest_r));
    end
  end

  // newest outstanding tag: oldest + live - 1, wrapped once
  assign sum_all = SW'(oldest_r) + SW'(live_r) - SW'(1);
  assign last_s  = (sum_all >= TC_S) ? (sum_all - TC_S) : sum_all;

  assign target = (op_r == OP_QONE) ? tag_idx : last_s[TW-1:0];
  // for query all on an empty ring this wraps to all ones and lands outside
  assign q_span = (op_r == OP_QONE) ? dist_one : TW'(live_r - CW'(1));
  assign dist_c = CW'(q_span);

  assign outside     = (dist_c >= live_r);
  assign pending_hit = (status[target] == TS_REQ) || (status[target] == TS_ISS);
  assign target_next = (target == LAST_T) ? '0 : target + TW'(1);
  assign next_ptr_inc = (next_ptr_r == LAST_T) ? '0 : next_ptr_r + TW'(1);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    tag_nxt       = tag_r;
    busy_nxt      = busy_r;
    oldest_nxt    = oldest_r;
    next_ptr_nxt  = next_ptr_r;
    live_nxt      = live_r;
    walk_cnt_nxt  = walk_cnt_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cell_ctl      = '0;
    sel_ptr       = oldest_r;
    granted       = '0;
    grant_ok      = 1'b0;
    fin           = 1'b0;
    granted_ext   = '0;
    live_ext      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          tag_nxt   = in_tdata[QTAG_W-1:0];
          busy_nxt  = in_tdata[QTAG_W +: BUSY_W];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        case (op_r)
          OP_ALLOC: begin
            if (live_r < TC_C) begin
              cell_ctl.alloc = 1'b1;
              sel_ptr        = next_ptr_r;
              granted_ext    = GEW'(next_ptr_r);
              granted        = granted_ext[GTAG_W-1:0];
              grant_ok       = 1'b1;
              next_ptr_nxt   = next_ptr_inc;
              live_nxt       = live_r + CW'(1);
            end
          end
          OP_RENEW: begin
            cell_ctl.renew = 1'b1;
          end
          default: begin
            if (op_r == OP_QONE && tag_oor) begin
              fin = 1'b0;
            end else if (outside) begin
              fin = 1'b1;
            end else if (pending_hit) begin
              fin = 1'b0;
            end else begin
              // retire oldest..target: token goes in at oldest, then walks
              fin           = 1'b1;
              cell_ctl.load = 1'b1;
              sel_ptr       = oldest_r;
              oldest_nxt    = target_next;
              live_nxt      = live_r - (dist_c + CW'(1));
              walk_cnt_nxt  = dist_c + CW'(1);
              state_nxt     = S_WALK;
            end
          end
        endcase
        live_ext = OEW'(live_nxt);
        res_nxt  = {live_ext[OUTS_W-1:0], (live_nxt != '0), fin, grant_ok, granted};
      end
      S_WALK: begin
        cell_ctl.walk = 1'b1;
        walk_cnt_nxt  = walk_cnt_r - CW'(1);
        if (walk_cnt_r == CW'(1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'(res_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      next_ptr_r  <= '0;
      live_r      <= '0;
      walk_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      next_ptr_r  <= next_ptr_nxt;
      live_r      <= live_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tag_r      <= tag_nxt;
    busy_r     <= busy_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign busy       = busy_r;

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= TC_C)
    else $error("outstanding count above ring size");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r == '0) |-> (oldest_r == next_ptr_r))
    else $error("empty ring with pointers apart");

  a_walk_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (walk_cnt_r != '0))
    else $error("retire walk with zero count");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside finish state");
`endif

endmodule

`default_nettype wire
